@@ rtl/dq_pkg.sv @@
// ============================================================================
// dq_pkg - shared types for the double-ended queue core
// Opcodes, result status codes, controller states and the command/status
// structs that join the controller to the datapath.
// ============================================================================
`default_nettype none

package dq_pkg;

    typedef enum logic [2:0] {
        OP_ADD_FRONT  = 3'd0,
        OP_ADD_BACK   = 3'd1,
        OP_REM_FRONT  = 3'd2,
        OP_REM_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_REVERSE    = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2,
        ST_RESP = 2'd3
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the input beat
        logic exec;     // apply the operation to pointers and store
        logic capture;  // latch the store read word into the result
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic peek_read;  // current operation needs a store read
    } dq_stat_t;

endpackage

`default_nettype wire

@@ rtl/double_ended_queue_with_reverse_core.sv @@
// ============================================================================
// double_ended_queue_with_reverse_core - bounded deque in a ring store
// Add, remove and peek at either end, plus a constant-time reverse that
// flips which physical end is the logical front. One result beat per input.
// ============================================================================
//
//  channel | dir | beat contents (tdata from bit 0 up)
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | opcode[2:0], data_in[DATA_WIDTH-1:0], zero pad to bytes
//  m_axis  | out | data_out[DATA_WIDTH-1:0], status[1:0], is_empty,
//          |     | entry_count[$clog2(DEPTH+1)-1:0], zero pad to bytes
//
// Sequence: a beat passes through accept, execute and result, plus a store
//   read for a peek of a non-empty deque, since the ring store RAM has a
//   registered read port. The result beat is presented from a register.
//   One beat is in flight at a time; s_tready is low from accept until the
//   result beat is taken.
// Reset: rst_n clears the state machine, head pointer, count and the
//   orientation flag. Store contents are not cleared; no clearing pass.
// Stalls: the result holds in its register while m_tready is low.
// ============================================================================
`default_nettype none

module double_ended_queue_with_reverse_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // opcode, data_in
    input  wire logic [((3 + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // data_out, status, is_empty, entry_count
    output logic [((DATA_WIDTH + 3 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready
);
    import dq_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = DATA_WIDTH + 3 + CW;
    localparam int OUT_T = ((OUT_W + 7) / 8) * 8;

    dq_cmd_t               cmd;
    dq_stat_t              stat;
    logic [DATA_WIDTH-1:0] data_out;
    status_t               status;
    logic                  is_empty;
    logic [CW-1:0]         entry_count;

    // sequence each beat: accept, execute, optional read, present result
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pointers, orientation flag, ring store and result register
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (s_tdata[2:0]),
        .data_in     (s_tdata[3 +: DATA_WIDTH]),
        .data_out    (data_out),
        .status      (status),
        .is_empty    (is_empty),
        .entry_count (entry_count)
    );

    // pack result fields, upper pad bits are zero
    assign m_tdata = OUT_T'({entry_count, is_empty, status, data_out});

endmodule

`default_nettype wire

@@ rtl/dq_ram.sv @@
// ============================================================================
// dq_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/dq_ctrl.sv @@
// ============================================================================
// dq_ctrl - sequencing controller for the deque core
// Walks each beat through execute, an optional store read, and the result.
// ============================================================================
`default_nettype none

module dq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t      cmd
);
    import dq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.peek_read ? ST_READ : ST_RESP;
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dq_datapath.sv @@
// ============================================================================
// dq_datapath - pointers, orientation flag, ring store and result register
// Executes one operation per exec command against the ring store.
// ============================================================================
`default_nettype none

module dq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dq_pkg::dq_cmd_t       cmd,
    output dq_pkg::dq_stat_t           stat,
    input  wire logic [2:0]            opcode,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    output logic      [DATA_WIDTH-1:0] data_out,
    output dq_pkg::status_t            status,
    output logic                       is_empty,
    output logic      [CW-1:0]         entry_count
);
    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int SW = CW + 1;

    opcode_t               op_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [IW-1:0]         front_reg;
    logic [IW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rev_reg;
    logic                  rev_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    status_t               out_status_reg;
    status_t               res_status;
    logic [CW-1:0]         out_count_reg;

    logic                  at_head;
    logic [IW-1:0]         front_dec;
    logic [IW-1:0]         front_inc;
    logic [SW-1:0]         sum_free;
    logic [SW-1:0]         sum_last;
    logic [IW-1:0]         tail_free;
    logic [IW-1:0]         tail_last;
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [IW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    // input beat and result registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode_t'(opcode);
            word_reg <= data_in;
        end
        if (cmd.exec)
        begin
            out_data_reg   <= '0;
            out_status_reg <= res_status;
            out_count_reg  <= count_next;
        end
        else if (cmd.capture)
        begin
            out_data_reg <= rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // ring arithmetic, wrap at DEPTH
    always_comb
    begin
        front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
        front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + IW'(1);
        sum_free  = SW'(front_reg) + SW'(count_reg);
        sum_last  = sum_free - SW'(1);
        tail_free = (sum_free >= SW'(DEPTH)) ? IW'(sum_free - SW'(DEPTH)) : IW'(sum_free);
        tail_last = (sum_last >= SW'(DEPTH)) ? IW'(sum_last - SW'(DEPTH)) : IW'(sum_last);
    end

    // front-side opcodes hit the head end unless the orientation is flipped
    always_comb
    begin
        at_head = rev_reg;
        case (op_reg)
            OP_ADD_FRONT, OP_REM_FRONT, OP_PEEK_FRONT: at_head = ~rev_reg;
            default:                                   at_head = rev_reg;
        endcase
    end

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        res_status     = STAT_OK;
        we             = 1'b0;
        waddr          = tail_free;
        stat.peek_read = 1'b0;
        raddr          = at_head ? front_reg : tail_last;
        case (op_reg)
            OP_ADD_FRONT, OP_ADD_BACK:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    we         = cmd.exec;
                    count_next = count_reg + CW'(1);
                    if (at_head)
                    begin
                        front_next = front_dec;
                        waddr      = front_dec;
                    end
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (count_reg == '0)
                begin
                    res_status = STAT_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (at_head)
                    begin
                        front_next = front_inc;
                    end
                end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (count_reg == '0)
                begin
                    res_status = STAT_EMPTY;
                end
                else
                begin
                    stat.peek_read = 1'b1;
                end
            end
            OP_REVERSE:
            begin
                rev_next = ~rev_reg;
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (word_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign data_out    = out_data_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign is_empty    = (out_count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/dq_checker.sv @@
// ============================================================================
// dq_checker - port-level checks for the deque core
// Watches the stream ports for one-beat-at-a-time sequencing and for
// consistent result fields.
// ============================================================================
`default_nettype none

module dq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [((DATA_WIDTH + 3 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    input wire logic m_tvalid,
    input wire logic m_tready
);
    import dq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]    res_status;
    logic          res_empty;
    logic [CW-1:0] res_count;

    assign res_status = m_tdata[DATA_WIDTH +: 2];
    assign res_empty  = m_tdata[DATA_WIDTH + 2];
    assign res_count  = m_tdata[DATA_WIDTH + 3 +: CW];

    // no new beat is taken while a result is pending
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // an accepted beat blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
        else $error("input not held off after accept");

    // hold a stalled result beat unchanged
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_empty == (res_count == '0)) && (res_count <= CW'(DEPTH)))
        else $error("empty flag or count inconsistent");

    // status is a known code, and a full-drop result reports a full deque
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == STAT_OK || res_status == STAT_EMPTY
                      || (res_status == STAT_FULL && res_count == CW'(DEPTH))))
        else $error("bad status code or full status without full count");

endmodule

bind double_ended_queue_with_reverse_core dq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

@@ tb/sv/double_ended_queue_with_reverse_core_test.sv @@
// ============================================================================
// double_ended_queue_with_reverse_core_test - self-checking deque bench
// Drives opcode/data beats into the core, predicts every result beat with a
// local ring-store model and compares all fields in order. A directed table
// covers empty, full and orientation cases. Random traffic follows, biased in
// phases toward filling, draining or mixing, with random stalls on both sides.
// ============================================================================
`default_nettype none

module double_ended_queue_with_reverse_core_test;
    import dq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int S_W          = ((3 + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_W          = ((DATA_WIDTH + 3 + CNT_W + 7) / 8) * 8;
    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1625;
    localparam int TOTAL_ITEMS  = DIR_ROWS + RANDOM_ITEMS;
    localparam int QUIET_ITEMS  = 150;    // tail of the run with no idling
    localparam int STALL_HOLD   = 200;    // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // opcode value outside the package enum; the core treats it as a no-op
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // result bit positions inside m_tdata
    localparam int ST_LSB  = DATA_WIDTH;
    localparam int EMP_BIT = DATA_WIDTH + 2;
    localparam int CNT_LSB = DATA_WIDTH + 3;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_out;
        status_t               status;
        logic                  is_empty;
        logic [CNT_W-1:0]      count;
    } deque_result_t;

    typedef struct packed {
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] data;
        logic                  golden;  // 1: use the typed-in result below
        deque_result_t         res;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic [S_W-1:0]   s_tdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [M_W-1:0]   m_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;

    // predictor state: a private copy of the ring store and its pointers
    logic [DATA_WIDTH-1:0] ring_word [DEPTH];
    int                    head_slot;
    int                    fill_level;
    bit                    flipped;

    deque_result_t         pending_results[$];
    stim_row_t             dir_table [DIR_ROWS];
    int                    mismatches;
    int                    results_seen;
    int                    cycles;
    bit                    quiet;
    bit                    sent_all;

    double_ended_queue_with_reverse_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hold reset low from the start, release on a rising edge, never again
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("double_ended_queue_with_reverse_core_test: errors");
            $finish;
        end
    end

    // Apply one operation to the local deque and return the result beat it
    // must produce. The logical front is the head end unless flipped.
    function automatic deque_result_t deque_apply(logic [2:0] op,
                                                  logic [DATA_WIDTH-1:0] word);
        deque_result_t r;
        bit            at_head;
        int            slot;
        r.data_out = '0;
        r.status   = STAT_OK;
        at_head    = (op[0] == 1'b0) ? !flipped : flipped;
        case (op)
            OP_ADD_FRONT, OP_ADD_BACK:
            begin
                if (fill_level >= DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (at_head)
                    begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        ring_word[head_slot] = word;
                    end
                    else
                    begin
                        ring_word[(head_slot + fill_level) % DEPTH] = word;
                    end
                    fill_level++;
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (fill_level == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    if (at_head)
                        head_slot = (head_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (fill_level == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    slot = at_head ? head_slot : (head_slot + fill_level - 1) % DEPTH;
                    r.data_out = ring_word[slot];
                end
            end
            OP_REVERSE: flipped = !flipped;
            default: ;
        endcase
        r.is_empty = (fill_level == 0);
        r.count    = fill_level[CNT_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t row(logic [2:0] op, logic [DATA_WIDTH-1:0] data,
                                      logic golden, logic [DATA_WIDTH-1:0] d_out,
                                      status_t st, logic emp, int cnt);
        stim_row_t t;
        t.op           = op;
        t.data         = data;
        t.golden       = golden;
        t.res.data_out = d_out;
        t.res.status   = st;
        t.res.is_empty = emp;
        t.res.count    = cnt[CNT_W-1:0];
        return t;
    endfunction

    // Pick an opcode with a bias: mode 0 fills, mode 1 drains, mode 2 mixes.
    function automatic logic [2:0] pick_op(int mode);
        int roll;
        int add_pct;
        int rem_pct;
        roll    = $urandom_range(0, 99);
        add_pct = (mode == 0) ? 60 : (mode == 1) ? 15 : 32;
        rem_pct = (mode == 0) ? 15 : (mode == 1) ? 60 : 32;
        if (roll < add_pct)
            return $urandom_range(0, 1) ? OP_ADD_BACK : OP_ADD_FRONT;
        else if (roll < add_pct + rem_pct)
            return $urandom_range(0, 1) ? OP_REM_BACK : OP_REM_FRONT;
        else if (roll < 95)
            return $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
        else
            return OP_REVERSE;
    endfunction

    // ------------------------------------------------------------------
    // Sender: walk the directed table, then random beats. Each beat is
    // offered at a rising edge and held until the core takes it.
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t     r;
        deque_result_t predicted;
        int            mode;
        int            mode_left;
        int            gap;
        int            k;
        int            pick;
        mode       = 2;
        mode_left  = 0;
        head_slot  = 0;
        fill_level = 0;
        flipped    = 1'b0;

        // Empty deque first: status and zero data can be read off directly.
        dir_table[0] = row(OP_PEEK_FRONT, 32'h1234_5678, 1, '0, STAT_EMPTY, 1, 0);
        dir_table[1] = row(OP_REM_BACK,   32'hFFFF_FFFF, 1, '0, STAT_EMPTY, 1, 0);
        dir_table[2] = row(OP_REVERSE,    32'h0,         1, '0, STAT_OK,    1, 0);
        dir_table[3] = row(OP_UNUSED,     32'hA5A5_A5A5, 1, '0, STAT_OK,    1, 0);
        // Reversed orientation now: front add lands on the tail end.
        dir_table[4] = row(OP_ADD_FRONT,  32'hFFFF_FFFF, 1, '0, STAT_OK,    0, 1);
        dir_table[5] = row(OP_ADD_BACK,   32'h0000_0000, 1, '0, STAT_OK,    0, 2);
        dir_table[6] = row(OP_PEEK_FRONT, 32'h0, 1, 32'hFFFF_FFFF, STAT_OK, 0, 2);
        dir_table[7] = row(OP_PEEK_BACK,  32'hFFFF_FFFF, 1, '0, STAT_OK,    0, 2);
        dir_table[8] = row(OP_REM_FRONT,  32'h0,         1, '0, STAT_OK,    0, 1);
        // Fill to capacity, alternating ends, with walking data.
        for (k = 9; k < DIR_ROWS - 1; k++)
            dir_table[k] = row((k % 2) ? OP_ADD_FRONT : OP_ADD_BACK,
                               32'h0000_0001 << (k - 9) | 32'h8000_0000 >> (k - 9),
                               0, '0, STAT_OK, 0, 0);
        dir_table[DIR_ROWS-1] = row(OP_ADD_BACK, 32'h5555_AAAA, 1, '0, STAT_FULL, 0, DEPTH);

        @(posedge rst_n);
        @(posedge clk);
        for (int i = 0; i < TOTAL_ITEMS; i++)
        begin
            if (i < DIR_ROWS)
            begin
                r = dir_table[i];
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                r.golden = 1'b0;
                r.op     = pick_op(mode);
                pick     = $urandom_range(0, 15);
                r.data   = (pick == 0) ? '0 : (pick == 1) ? '1 : DATA_WIDTH'($urandom);
            end
            quiet = (i >= TOTAL_ITEMS - QUIET_ITEMS);

            // idle burst between beats; drop valid only when a gap is taken
            gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(S_W - 3 - DATA_WIDTH){1'b0}}, r.data, r.op};

            // inputs only move at rising edges, so tready at the falling edge
            // tells whether the next rising edge completes the handshake
            forever
            begin
                @(negedge clk);
                if (s_tready)
                    break;
            end
            @(posedge clk);
            predicted = deque_apply(r.op, r.data);
            pending_results.push_back(r.golden ? r.res : predicted);
        end
        s_tvalid <= 1'b0;
        sent_all = 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off that backs the
    // core up while the sender keeps its beat offered.
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        bit held_once;
        burst     = 0;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_once && results_seen >= 300 && !quiet)
            begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_HOLD) @(posedge clk);
            end
            if (burst > 0 && !quiet)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each result beat against the oldest expectation. Sampling at the
    // falling edge sees exactly what the next rising edge will take.
    always @(negedge clk)
    begin
        deque_result_t want;
        deque_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            got.data_out = m_tdata[DATA_WIDTH-1:0];
            got.status   = status_t'(m_tdata[ST_LSB +: 2]);
            got.is_empty = m_tdata[EMP_BIT];
            got.count    = m_tdata[CNT_LSB +: CNT_W];
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: data %h status %0d empty %0d count %0d",
                             got.data_out, got.status, got.is_empty, got.count);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.data_out !== want.data_out || got.status !== want.status ||
                    got.is_empty !== want.is_empty || got.count !== want.count)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display({"beat %0d: want data %h st %0d emp %0d cnt %0d, ",
                                  "got data %h st %0d emp %0d cnt %0d"},
                                 results_seen, want.data_out, want.status,
                                 want.is_empty, want.count, got.data_out,
                                 got.status, got.is_empty, got.count);
                    mismatches++;
                end
            end
        end
    end

    // Wrap up: wait for the last result, idle through a drain period to
    // catch stray beats, then report.
    initial
    begin
        wait (sent_all);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("double_ended_queue_with_reverse_core_test: clean");
        else
            $display("double_ended_queue_with_reverse_core_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
